/* design/aarm_pkg.sv */
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants of the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aarm_pkg;

	// pipeline depth of the matrix core
	localparam int NSTAGE = 56;

	// row numbering of the result channel
	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd3;

	// fixed-point constants
	localparam logic [17:0] ONE_Q16 = 18'd65536;
	localparam logic [17:0] SAT_HI  = 18'h1FFFF;
	localparam logic [17:0] SAT_LO  = 18'h20000;
	localparam logic signed [63:0] SAT_MAX = 64'sd131071;
	localparam logic signed [63:0] SAT_MIN = -64'sd131072;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
	localparam logic signed [33:0] RND_Q14 = 34'sd8192;
	localparam logic signed [19:0] ONE_C = 20'sd65536;
	localparam logic signed [63:0] RND_Q32 = 64'sd2147483648;

	// arctangent of 2^-i in 2^-32 turn units
	localparam logic [31:0] ATAN_TURN [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	// everything an item carries down the pipeline
	typedef struct packed {
		logic                     func;
		logic [15:0]              angle;
		logic signed [15:0]       cos_in;
		logic signed [15:0]       sin_in;
		logic [2:0][15:0]         ax;
		logic [2:0][31:0]         psq;
		logic [31:0]              sq;
		logic                     zero;
		logic signed [33:0]       cx;
		logic signed [33:0]       cy;
		logic signed [33:0]       cz;
		logic                     flip;
		logic [35:0]              rt_rem;
		logic [31:0]              rt_root;
		logic signed [19:0]       c;
		logic signed [19:0]       s;
		logic signed [19:0]       t;
		logic [2:0][48:0]         dv_num;
		logic [2:0][32:0]         dv_rem;
		logic [2:0][16:0]         dv_q;
		logic [2:0][17:0]         a;
		logic [8:0][35:0]         pa;
		logic [2:0][37:0]         sa;
		logic [8:0][63:0]         m;
		logic [8:0][17:0]         ent;
	} aarm_pipe_t;

	// finished 3x3 matrix leaving the core
	typedef struct packed {
		logic             valid;
		logic [8:0][17:0] ent;
	} aarm_mat_t;

endpackage

`default_nettype wire

/* design/aarm_core.sv */
// ----------------------------------------------------------------------------
// aarm_core
// Stall-capable pipeline: axis squares, cordic, square root, three dividers
// and the Rodrigues products, ending in a saturated 3x3 matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aarm_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    in_user,
	input  wire  [95:0]            in_data,
	output aarm_pkg::aarm_mat_t    mat,
	input  wire                    take
);

	localparam int N = aarm_pkg::NSTAGE;

	aarm_pkg::aarm_pipe_t in_pipe;
	aarm_pkg::aarm_pipe_t nx      [1:N];
	aarm_pkg::aarm_pipe_t pipe_s  [1:N];
	logic                 vld_s   [1:N];
	logic                 adv     [1:N];

	// unpack the input transaction
	always_comb begin
		in_pipe        = '0;
		in_pipe.func   = in_user;
		in_pipe.angle  = in_data[15:0];
		in_pipe.cos_in = $signed(in_data[31:16]);
		in_pipe.sin_in = $signed(in_data[47:32]);
		in_pipe.ax[0]  = in_data[63:48];
		in_pipe.ax[1]  = in_data[79:64];
		in_pipe.ax[2]  = in_data[95:80];
	end

	assign in_ready  = adv[1];
	assign mat.valid = vld_s[N];
	assign mat.ent   = pipe_s[N].ent;

	for (genvar j = 1; j <= N; j++) begin : g_stage
		localparam int CI = (j >= 2 && j <= 17) ? j - 2 : 0;
		localparam int SK = (j >= 3 && j <= 34) ? j - 3 : 0;
		localparam int PH = (SK < 16) ? 31 - 2 * SK : 1;
		localparam int DB = (j >= 36 && j <= 52) ? 52 - j : 0;

		aarm_pkg::aarm_pipe_t src;
		aarm_pkg::aarm_pipe_t n;
		logic                 vin;
		logic signed [33:0]   zi;
		logic signed [33:0]   xs;
		logic signed [33:0]   ys;
		logic [1:0]           pr;
		logic [35:0]          r2s;
		logic [35:0]          trs;
		logic [32:0]          r2d;
		logic [32:0]          dvs;
		logic [15:0]          mag;
		logic [17:0]          aa;
		logic signed [63:0]   mm;
		logic signed [63:0]   rd;

		if (j == 1) begin : g_src
			assign src = in_pipe;
			assign vin = in_valid;
		end else begin : g_src
			assign src = pipe_s[j-1];
			assign vin = vld_s[j-1];
		end

		// stall chain: a stage loads when empty or when its item moves on
		if (j == N) begin : g_adv
			assign adv[j] = !vld_s[j] || take;
		end else begin : g_adv
			assign adv[j] = !vld_s[j] || adv[j+1];
		end

		// work of this stage
		always_comb begin
			n   = src;
			zi  = '0;
			xs  = '0;
			ys  = '0;
			pr  = '0;
			r2s = '0;
			trs = '0;
			r2d = '0;
			dvs = '0;
			mag = '0;
			aa  = '0;
			mm  = '0;
			rd  = '0;
			// squares of the axis and cordic angle fold
			if (j == 1) begin
				for (int i = 0; i < 3; i++) begin
					n.psq[i] = 32'($signed(32'($signed(src.ax[i])))
						* $signed(32'($signed(src.ax[i]))));
				end
				zi     = 34'($signed({src.angle, 16'h0000}));
				n.flip = 1'b0;
				if (zi > aarm_pkg::QUARTER_TURN) begin
					zi     = zi - aarm_pkg::HALF_TURN;
					n.flip = 1'b1;
				end else if (zi < -aarm_pkg::QUARTER_TURN) begin
					zi     = zi + aarm_pkg::HALF_TURN;
					n.flip = 1'b1;
				end
				n.cz = zi;
				n.cx = aarm_pkg::CORDIC_GAIN;
				n.cy = '0;
			end
			// sum of squares, zero axis flag, root start
			if (j == 2) begin
				n.sq      = src.psq[0] + src.psq[1] + src.psq[2];
				n.zero    = (src.ax[0] == '0) && (src.ax[1] == '0) && (src.ax[2] == '0);
				n.rt_rem  = '0;
				n.rt_root = '0;
			end
			// one cordic rotation
			if (j >= 2 && j <= 17) begin
				if (src.cz >= 0) begin
					n.cx = src.cx - (src.cy >>> CI);
					n.cy = src.cy + (src.cx >>> CI);
					n.cz = src.cz - $signed({2'b00, aarm_pkg::ATAN_TURN[CI]});
				end else begin
					n.cx = src.cx + (src.cy >>> CI);
					n.cy = src.cy - (src.cx >>> CI);
					n.cz = src.cz + $signed({2'b00, aarm_pkg::ATAN_TURN[CI]});
				end
			end
			// one root digit, low pairs are zero
			if (j >= 3 && j <= 34) begin
				pr  = (SK < 16) ? src.sq[PH -: 2] : 2'b00;
				r2s = {src.rt_rem[33:0], pr};
				trs = {2'b00, src.rt_root, 2'b01};
				if (r2s >= trs) begin
					n.rt_rem  = r2s - trs;
					n.rt_root = {src.rt_root[30:0], 1'b1};
				end else begin
					n.rt_rem  = r2s;
					n.rt_root = {src.rt_root[30:0], 1'b0};
				end
			end
			// cosine and sine in q16
			if (j == 18) begin
				xs = src.flip ? -src.cx : src.cx;
				ys = src.flip ? -src.cy : src.cy;
				if (src.func) begin
					n.c = $signed({{3{src.cos_in[15]}}, src.cos_in, 1'b0});
					n.s = $signed({{3{src.sin_in[15]}}, src.sin_in, 1'b0});
				end else begin
					n.c = 20'((xs + aarm_pkg::RND_Q14) >>> 14);
					n.s = 20'((ys + aarm_pkg::RND_Q14) >>> 14);
				end
			end
			// dividend with half divisor for rounding
			if (j == 35) begin
				for (int i = 0; i < 3; i++) begin
					mag         = src.ax[i][15] ? 16'(-src.ax[i]) : src.ax[i];
					n.dv_num[i] = {1'b0, mag, 32'h0} + 49'(src.rt_root >> 1);
					n.dv_rem[i] = {1'b0, n.dv_num[i][48:17]};
					n.dv_q[i]   = '0;
				end
			end
			// one quotient bit per divider
			if (j >= 36 && j <= 52) begin
				dvs = {1'b0, src.rt_root};
				for (int i = 0; i < 3; i++) begin
					r2d = {src.dv_rem[i][31:0], src.dv_num[i][DB]};
					if (r2d >= dvs) begin
						n.dv_rem[i] = r2d - dvs;
						n.dv_q[i]   = {src.dv_q[i][15:0], 1'b1};
					end else begin
						n.dv_rem[i] = r2d;
						n.dv_q[i]   = {src.dv_q[i][15:0], 1'b0};
					end
				end
			end
			// signed unit axis and one minus cosine
			if (j == 53) begin
				for (int i = 0; i < 3; i++) begin
					aa     = {1'b0, src.dv_q[i]};
					n.a[i] = src.ax[i][15] ? 18'(-aa) : aa;
				end
				n.t = aarm_pkg::ONE_C - src.c;
			end
			// axis outer product and sine terms
			if (j == 54) begin
				for (int r = 0; r < 3; r++) begin
					for (int k = 0; k < 3; k++) begin
						n.pa[r*3+k] = 36'($signed(src.a[r])) * 36'($signed(src.a[k]));
					end
					n.sa[r] = 38'($signed(src.s)) * 38'($signed(src.a[r]));
				end
			end
			// rodrigues sums in q48
			if (j == 55) begin
				for (int i = 0; i < 9; i++) begin
					mm = 64'(56'($signed(src.pa[i])) * 56'(src.t));
					if (i == 0 || i == 4 || i == 8) begin
						mm = mm + (64'(src.c) <<< 32);
					end
					n.m[i] = mm;
				end
				n.m[1] = $signed(n.m[1]) - (64'($signed(src.sa[2])) <<< 16);
				n.m[3] = $signed(n.m[3]) + (64'($signed(src.sa[2])) <<< 16);
				n.m[2] = $signed(n.m[2]) + (64'($signed(src.sa[1])) <<< 16);
				n.m[6] = $signed(n.m[6]) - (64'($signed(src.sa[1])) <<< 16);
				n.m[5] = $signed(n.m[5]) - (64'($signed(src.sa[0])) <<< 16);
				n.m[7] = $signed(n.m[7]) + (64'($signed(src.sa[0])) <<< 16);
			end
			// round, saturate, identity for a zero axis
			if (j == 56) begin
				for (int i = 0; i < 9; i++) begin
					rd = ($signed(src.m[i]) + aarm_pkg::RND_Q32) >>> 32;
					if (src.zero) begin
						n.ent[i] = (i == 0 || i == 4 || i == 8) ? aarm_pkg::ONE_Q16 : '0;
					end else if (rd > aarm_pkg::SAT_MAX) begin
						n.ent[i] = aarm_pkg::SAT_HI;
					end else if (rd < aarm_pkg::SAT_MIN) begin
						n.ent[i] = aarm_pkg::SAT_LO;
					end else begin
						n.ent[i] = rd[17:0];
					end
				end
			end
		end

		assign nx[j] = n;

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv[j]) begin
				vld_s[j] <= vin;
			end
		end

		// stage payload
		always_ff @(posedge clk) begin
			if (adv[j]) begin
				pipe_s[j] <= nx[j];
			end
		end
	end

endmodule

`default_nettype wire

/* design/axis_angle_rotation_matrix_top.sv */
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// Rotation matrix from axis and angle (Rodrigues), sent as four rows of a
// 4x4 homogeneous matrix in signed Q2.16.
//
// channel  dir  tdata                                       tuser        tlast
// s_axis   in   angle, cos_in, sin_in, axis_x/y/z (96 bits) func         -
// m_axis   out  col0, col1, col2, col3 (72 bits)            row_index    last
//
// The output sends four row transactions per matrix, and a new matrix is taken
// only when idle or as the last row leaves; the core pipeline itself takes one per cycle when not stalled.
// An item passes the 56 pipeline stages and then the matrix holding register before its first row.
// Reset clears all valid bits and the row counter; no payload is reset.
// A stall on m_axis holds the rows and fills the pipeline before s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module axis_angle_rotation_matrix_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [95:0] s_tdata,   // angle, cos_in, sin_in, axis_x, axis_y, axis_z
	input  wire         s_tuser,   // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // col0, col1, col2, col3
	output logic [1:0]  m_tuser,   // row_index
	output logic        m_tlast
);

	aarm_pkg::aarm_mat_t mat;
	logic                take;
	logic                busy_q;
	logic [1:0]          row_q;
	logic [8:0][17:0]    mat_q;

	aarm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_user  (s_tuser),
		.in_data  (s_tdata),
		.mat      (mat),
		.take     (take)
	);

	// load a new matrix when idle or when the last row leaves
	assign take = mat.valid && (!busy_q || (m_tready && row_q == aarm_pkg::ROW_LAST));

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= aarm_pkg::ROW_FIRST;
		end else if (take) begin
			busy_q <= 1'b1;
			row_q  <= aarm_pkg::ROW_FIRST;
		end else if (busy_q && m_tready) begin
			if (row_q == aarm_pkg::ROW_LAST) begin
				busy_q <= 1'b0;
				row_q  <= aarm_pkg::ROW_FIRST;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	// matrix holding register
	always_ff @(posedge clk) begin
		if (take) begin
			mat_q <= mat.ent;
		end
	end

	// row selection
	always_comb begin
		m_tvalid = busy_q;
		m_tuser  = row_q;
		m_tlast  = (row_q == aarm_pkg::ROW_LAST);
		case (row_q)
			2'd0:    m_tdata = {18'd0, mat_q[2], mat_q[1], mat_q[0]};
			2'd1:    m_tdata = {18'd0, mat_q[5], mat_q[4], mat_q[3]};
			2'd2:    m_tdata = {18'd0, mat_q[8], mat_q[7], mat_q[6]};
			default: m_tdata = {aarm_pkg::ONE_Q16, 54'd0};
		endcase
	end

`ifndef SYNTHESIS
	a_take_starts_row0: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q && row_q == aarm_pkg::ROW_FIRST)
		else $error("new matrix does not start at row 0");

	a_row_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && m_tready && row_q != aarm_pkg::ROW_LAST
		|=> busy_q && row_q == $past(row_q) + 2'd1)
		else $error("row counter skipped or stopped");

	a_idle_row0: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> row_q == aarm_pkg::ROW_FIRST)
		else $error("row counter not at row 0 while idle");
`endif

endmodule

`default_nettype wire

/* tb/tb_axis_angle_rotation_matrix_top.sv */
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix_top
// Self-checking bench for the axis-angle rotation matrix block: a directed
// table followed by random transactions, all checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_axis_angle_rotation_matrix_top;

	localparam int N_RANDOM   = 450;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]         row;
		logic signed [17:0] c0;
		logic signed [17:0] c1;
		logic signed [17:0] c2;
		logic signed [17:0] c3;
		logic               lst;
	} row_t;

	typedef struct {
		logic        func;
		logic [15:0] angle;
		logic [15:0] cos_in;
		logic [15:0] sin_in;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		bit          ident;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	row_t   rows_due[$];
	row_t   rows_ident[$];
	int     n_err;
	int     n_items;
	int     n_rows;
	int     idle_cnt;

	axis_angle_rotation_matrix_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// arithmetic helpers
	function automatic longint fl_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return longint'(res);
	endfunction

	// cordic cosine/sine of a binary angle, rounded to q.16
	task automatic angle_cos_sin(input logic [15:0] ang, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z >= (64'sd1 << 31)) z -= 64'sd1 << 32;
		if (z > (64'sd1 << 30)) begin
			z -= 64'sd1 << 31;
			flip = 1;
		end else if (z < -(64'sd1 << 30)) begin
			z += 64'sd1 << 31;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - fl_shr(y, i);
				y = y + fl_shr(x, i);
				z -= longint'(aarm_pkg::ATAN_TURN[i]);
			end else begin
				nx = x + fl_shr(y, i);
				y = y - fl_shr(x, i);
				z += longint'(aarm_pkg::ATAN_TURN[i]);
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = fl_shr(x + 8192, 14);
		s = fl_shr(y + 8192, 14);
	endtask

	function automatic longint unit_comp(longint v, longint n);
		longint unsigned mag, q;
		mag = (v < 0) ? -v : v;
		q = ((mag << 32) + (longint'(n) >> 1)) / longint'(n);
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [17:0] round_sat(longint q48);
		longint v;
		v = fl_shr(q48 + (64'sd1 << 31), 32);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	// rodrigues matrix rows for one transaction
	task automatic predict_rows(input stim_t st);
		longint vx, vy, vz, c, s, t, n;
		longint a[3];
		longint m[3][3];
		row_t rw;
		vx = longint'($signed(st.ax));
		vy = longint'($signed(st.ay));
		vz = longint'($signed(st.az));
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				m[r][k] = (r == k) ? (64'sd65536 << 32) : 0;
		if (vx != 0 || vy != 0 || vz != 0) begin
			n = int_sqrt(longint'(vx*vx + vy*vy + vz*vz) << 32);
			if (st.func) begin
				c = longint'($signed(st.cos_in)) * 2;
				s = longint'($signed(st.sin_in)) * 2;
			end else begin
				angle_cos_sin(st.angle, c, s);
			end
			t = 65536 - c;
			a[0] = unit_comp(vx, n);
			a[1] = unit_comp(vy, n);
			a[2] = unit_comp(vz, n);
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					m[r][k] = a[r] * a[k] * t + ((r == k) ? c * (64'sd1 << 32) : 0);
			m[0][1] -= s * a[2] * 65536;
			m[1][0] += s * a[2] * 65536;
			m[0][2] += s * a[1] * 65536;
			m[2][0] -= s * a[1] * 65536;
			m[1][2] -= s * a[0] * 65536;
			m[2][1] += s * a[0] * 65536;
		end
		for (int r = 0; r < 4; r++) begin
			rw.row = r[1:0];
			rw.c0 = (r < 3) ? round_sat(m[r][0]) : '0;
			rw.c1 = (r < 3) ? round_sat(m[r][1]) : '0;
			rw.c2 = (r < 3) ? round_sat(m[r][2]) : '0;
			rw.c3 = (r < 3) ? 18'sd0 : 18'sd65536;
			rw.lst = (r == 3);
			rows_due.push_back(rw);
		end
	endtask

	// drive one transaction and wait until it is accepted
	task automatic send_item(input stim_t st);
		s_tvalid <= 1'b1;
		s_tuser  <= st.func;
		s_tdata  <= {st.az, st.ay, st.ax, st.sin_in, st.cos_in, st.angle};
		predict_rows(st);
		if (st.ident) begin
			// typed identity rows replace the computed ones
			repeat (4) void'(rows_due.pop_back());
			foreach (rows_ident[i]) rows_due.push_back(rows_ident[i]);
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_items++;
	endtask

	function automatic stim_t mk(logic f, logic [15:0] ang, logic [15:0] c, logic [15:0] s,
			logic [15:0] x, logic [15:0] y, logic [15:0] z, bit id);
		stim_t st;
		st.func = f; st.angle = ang; st.cos_in = c; st.sin_in = s;
		st.ax = x; st.ay = y; st.az = z; st.ident = id;
		return st;
	endfunction

	function automatic logic [15:0] rnd_axis();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		stim_t dir_tab[$];
		stim_t st;
		int burst;
		row_t rw;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		n_err = 0; n_items = 0; n_rows = 0;
		for (int r = 0; r < 4; r++) begin
			rw.row = r[1:0];
			rw.c0 = (r == 0) ? 18'sd65536 : 18'sd0;
			rw.c1 = (r == 1) ? 18'sd65536 : 18'sd0;
			rw.c2 = (r == 2) ? 18'sd65536 : 18'sd0;
			rw.c3 = (r == 3) ? 18'sd65536 : 18'sd0;
			rw.lst = (r == 3);
			rows_ident.push_back(rw);
		end
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: zero axis, axis extremes, angle folds, raw pairs
		dir_tab.push_back(mk(0, 16'h1234, 0, 0, 0, 0, 0, 1));
		dir_tab.push_back(mk(1, 0, 16'h8000, 16'h7FFF, 0, 0, 0, 1));
		dir_tab.push_back(mk(0, 16'h0000, 0, 0, 16'd1, 0, 0, 0));
		dir_tab.push_back(mk(0, 16'h4000, 0, 0, 0, 0, 16'd100, 0));
		dir_tab.push_back(mk(0, 16'h8000, 0, 0, 0, 16'h7FFF, 0, 0));
		dir_tab.push_back(mk(0, 16'hC000, 0, 0, 16'h8000, 0, 0, 0));
		dir_tab.push_back(mk(0, 16'hFFFF, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0));
		dir_tab.push_back(mk(0, 16'h7FFF, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0));
		dir_tab.push_back(mk(0, 16'h4001, 0, 0, 16'hFFFF, 16'd1, 16'd2, 0));
		dir_tab.push_back(mk(0, 16'hBFFF, 0, 0, 16'd3, 16'hFFFE, 16'd7, 0));
		dir_tab.push_back(mk(0, 16'h2000, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 0));
		dir_tab.push_back(mk(1, 0, 16'h7FFF, 16'h0000, 16'd5, 16'd5, 0, 0));
		dir_tab.push_back(mk(1, 16'hFFFF, 16'h8000, 16'h8000, 16'd1, 16'h8000, 16'h7FFF, 0));
		dir_tab.push_back(mk(1, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd1, 0));
		dir_tab.push_back(mk(1, 0, 16'h8000, 16'h7FFF, 0, 0, 16'hFFFF, 0));
		dir_tab.push_back(mk(1, 0, 0, 0, 16'd9, 16'd0, 16'hFFF0, 0));
		foreach (dir_tab[i]) send_item(dir_tab[i]);

		// random part: mostly nonzero axes, some zero axes
		for (int i = 0; i < N_RANDOM; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && i < N_RANDOM; b++, i++) begin
				st.func = 1'($urandom_range(0, 1));
				st.angle = 16'($urandom);
				st.cos_in = 16'($urandom);
				st.sin_in = 16'($urandom);
				if ($urandom_range(0, 19) == 0) begin
					st.ax = '0; st.ay = '0; st.az = '0;
				end else begin
					st.ax = rnd_axis(); st.ay = rnd_axis(); st.az = rnd_axis();
				end
				st.ident = 1'b0;
				send_item(st);
			end
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (rows_due.size() != 0) @(posedge clk);
		repeat (aarm_pkg::NSTAGE + 10) @(posedge clk);
		$display("covered %0d matrices, %0d rows checked (angle and cos/sin paths, zero axis)",
			n_items, n_rows);
		if (n_err == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver stall pattern: random stretches of full speed, light stalls or heavy stalls
	initial begin
		int phase;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			phase = $urandom_range(0, 2);
			repeat ($urandom_range(10, 60)) begin
				@(posedge clk);
				case (phase)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// row checker
	always @(posedge clk) begin
		row_t exp_r;
		logic signed [17:0] a0, a1, a2, a3;
		if (arst_n && m_tvalid && m_tready) begin
			a0 = m_tdata[17:0];
			a1 = m_tdata[35:18];
			a2 = m_tdata[53:36];
			a3 = m_tdata[71:54];
			n_rows++;
			if (rows_due.size() == 0) begin
				$error("row transaction with no matrix pending");
				n_err++;
			end else begin
				exp_r = rows_due.pop_front();
				if (m_tuser !== exp_r.row) begin
					$error("row_index: expected %0d actual %0d", exp_r.row, m_tuser);
					n_err++;
				end
				if (a0 !== exp_r.c0) begin
					$error("col0: expected %0d actual %0d", exp_r.c0, a0);
					n_err++;
				end
				if (a1 !== exp_r.c1) begin
					$error("col1: expected %0d actual %0d", exp_r.c1, a1);
					n_err++;
				end
				if (a2 !== exp_r.c2) begin
					$error("col2: expected %0d actual %0d", exp_r.c2, a2);
					n_err++;
				end
				if (a3 !== exp_r.c3) begin
					$error("col3: expected %0d actual %0d", exp_r.c3, a3);
					n_err++;
				end
				if (m_tlast !== exp_r.lst) begin
					$error("last: expected %0d actual %0d", exp_r.lst, m_tlast);
					n_err++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
